// ===== sv/assert_macros.svh =====
// Concurrent assertion helpers, sampled on the rising clock edge and
// disabled while the synchronous active-low reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Consequent must hold at the same edge as the antecedent.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== sv/psfc_pkg.sv =====
`default_nettype none

package psfc_pkg;

    localparam int FRAME_LENGTH = 32;
    localparam int POS_W        = $clog2(FRAME_LENGTH);
    localparam int NUM_FIELDS   = 6;
    localparam int SEL_W        = 3;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

    localparam logic [POS_W-1:0] LAST_POS   = POS_W'(FRAME_LENGTH - 1);
    localparam logic [7:0]       START_BYTE = 8'h42;

    localparam logic [1:0] MODE_MASS  = 2'd0;
    localparam logic [1:0] MODE_COUNT = 2'd1;

    localparam logic [SEL_W-1:0] SEL_MASS_SMALL   = 3'd0;
    localparam logic [SEL_W-1:0] SEL_MASS_MID     = 3'd1;
    localparam logic [SEL_W-1:0] SEL_MASS_LARGE   = 3'd2;
    localparam logic [SEL_W-1:0] SEL_COUNT_FINE   = 3'd3;
    localparam logic [SEL_W-1:0] SEL_COUNT_MEDIUM = 3'd4;
    localparam logic [SEL_W-1:0] SEL_COUNT_COARSE = 3'd5;

    localparam logic [POS_W-1:0] FIELD_OFFSET [NUM_FIELDS] = '{
        POS_W'(6), POS_W'(8), POS_W'(10), POS_W'(18), POS_W'(20), POS_W'(22)
    };

    typedef enum logic {
        QK_FIELD = 1'b0,
        QK_END   = 1'b1
    } t_qkind;

    typedef struct packed {
        t_qkind           kind;
        logic [SEL_W-1:0] sel;
        logic [7:0]       data;
    } t_qword;

    typedef struct packed {
        logic             hit;
        logic [SEL_W-1:0] sel;
    } t_field_hit;

    function automatic t_field_hit field_lookup(input logic [POS_W-1:0] pos);
        t_field_hit r;
        r = '0;
        for (int k = 0; k < NUM_FIELDS; k++) begin
            if (pos == FIELD_OFFSET[k]) begin
                r.hit = 1'b1;
                r.sel = SEL_W'(k);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/particle_sensor_frame_capture.sv =====
// Particle sensor frame capture. Takes one received serial byte per cycle on
// the input channel (i_valid / o_stall); a 0x42 byte opens a 32-byte frame,
// and once the last byte of the frame is taken one word leaves on the output
// channel (o_valid / i_stall) with the three mass bytes, the three particle
// counts (five times their bytes) and a flag set when the values picked by
// display_mode (0 mass, 1 counts, 2 or 3 none) differ from the previous
// frame. A word is registered once the end mark leaves the queue, later
// only while the previous word still waits on a stalled output. The front
// tracks the frame and passes only the six useful bytes and an end mark
// through a four-entry queue, so input is held off only once that queue fills
// while a finished word waits on a stalled output. Write display_mode only
// while no frame is in flight. No checksum is checked.
`default_nettype none

`include "assert_macros.svh"

module particle_sensor_frame_capture
    import psfc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_data,
    input  wire logic        i_valid,
    output      logic        o_stall,
    input  wire logic [7:0]  i_rx_byte,
    output      logic        o_valid,
    input  wire logic        i_stall,
    output      logic [7:0]  o_mass_small,
    output      logic [7:0]  o_mass_mid,
    output      logic [7:0]  o_mass_large,
    output      logic [10:0] o_count_fine,
    output      logic [10:0] o_count_medium,
    output      logic [10:0] o_count_coarse,
    output      logic        o_values_changed
);

    logic   [1:0] r_display_mode;
    logic         q_push;
    t_qword       q_in_word;
    logic         q_full;
    logic         q_valid;
    t_qword       q_word;
    logic         q_pop;
    logic         q_end;

    assign q_end = q_valid && (q_word.kind == QK_END);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_display_mode <= MODE_MASS;
        end else if (i_cfg_we) begin
            r_display_mode <= i_cfg_data;
        end
    end

    psfc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_rx_byte (i_rx_byte),
        .i_full    (q_full),
        .o_push    (q_push),
        .o_word    (q_in_word)
    );

    psfc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_word  (q_in_word),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_word  (q_word),
        .i_pop   (q_pop)
    );

    psfc_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_display_mode   (r_display_mode),
        .i_q_valid        (q_valid),
        .i_q_word         (q_word),
        .o_q_pop          (q_pop),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_mass_small     (o_mass_small),
        .o_mass_mid       (o_mass_mid),
        .o_mass_large     (o_mass_large),
        .o_count_fine     (o_count_fine),
        .o_count_medium   (o_count_medium),
        .o_count_coarse   (o_count_coarse),
        .o_values_changed (o_values_changed)
    );

    `ASSERT_IMPLY(a_no_push_when_full, i_clk, i_rst_n, q_push, !q_full, "push into full queue")
    `ASSERT_IMPLY(a_end_waits, i_clk, i_rst_n, o_valid && i_stall && q_end, !q_pop, "end popped")
    `ASSERT_IMPLY(a_word_from_end, i_clk, i_rst_n, $rose(o_valid), $past(q_pop && q_end), "no end")

endmodule

`default_nettype wire

// ===== sv/psfc_front.sv =====
`default_nettype none

module psfc_front
    import psfc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output      logic       o_stall,
    input  wire logic [7:0] i_rx_byte,
    input  wire logic       i_full,
    output      logic       o_push,
    output      t_qword     o_word
);

    logic             r_active;
    logic [POS_W-1:0] r_pos;
    logic             n_active;
    logic [POS_W-1:0] n_pos;
    logic             accept;
    logic             in_frame;
    t_field_hit       hit;

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;
    assign hit     = field_lookup(r_pos);

    always_comb begin
        n_active = r_active;
        n_pos    = r_pos;
        o_push   = 1'b0;
        o_word   = '{kind: QK_FIELD, sel: hit.sel, data: i_rx_byte};
        in_frame = r_active || (i_rx_byte == START_BYTE);
        if (accept && in_frame) begin
            if (r_pos == LAST_POS) begin
                // frame complete: close it and hand the end mark to the back
                n_active    = 1'b0;
                n_pos       = '0;
                o_push      = 1'b1;
                o_word.kind = QK_END;
            end else begin
                n_active = 1'b1;
                n_pos    = r_pos + 1'b1;
                o_push   = hit.hit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_pos    <= '0;
        end else begin
            r_active <= n_active;
            r_pos    <= n_pos;
        end
    end

endmodule

`default_nettype wire

// ===== sv/psfc_queue.sv =====
`default_nettype none

module psfc_queue
    import psfc_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_qword i_word,
    output      logic   o_full,
    output      logic   o_valid,
    output      t_qword o_word,
    input  wire logic   i_pop
);

    t_qword            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QPTR_W:0]   r_count;

    assign o_full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_word  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== sv/psfc_back.sv =====
`default_nettype none

module psfc_back
    import psfc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [1:0]  i_display_mode,
    input  wire logic        i_q_valid,
    input  wire t_qword      i_q_word,
    output      logic        o_q_pop,
    output      logic        o_valid,
    input  wire logic        i_stall,
    output      logic [7:0]  o_mass_small,
    output      logic [7:0]  o_mass_mid,
    output      logic [7:0]  o_mass_large,
    output      logic [10:0] o_count_fine,
    output      logic [10:0] o_count_medium,
    output      logic [10:0] o_count_coarse,
    output      logic        o_values_changed
);

    logic [7:0]  r_cur  [NUM_FIELDS];
    logic [7:0]  r_last [NUM_FIELDS];
    logic        r_out_valid;
    logic [7:0]  r_mass [3];
    logic [10:0] r_cnt  [3];
    logic        r_changed;

    logic        pop_end;
    logic        mass_diff;
    logic        cnt_diff;
    logic        changed;
    logic [10:0] cnt [3];

    assign o_q_pop = i_q_valid &&
                     (i_q_word.kind == QK_FIELD || !r_out_valid || !i_stall);
    assign pop_end = o_q_pop && (i_q_word.kind == QK_END);

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            cnt[k] = 11'({r_cur[3 + k], 2'b00}) + 11'(r_cur[3 + k]);
        end
        mass_diff = (r_cur[SEL_MASS_SMALL]   != r_last[SEL_MASS_SMALL])  ||
                    (r_cur[SEL_MASS_MID]     != r_last[SEL_MASS_MID])    ||
                    (r_cur[SEL_MASS_LARGE]   != r_last[SEL_MASS_LARGE]);
        // scaling by five is one-to-one, so compare the raw count bytes
        cnt_diff  = (r_cur[SEL_COUNT_FINE]   != r_last[SEL_COUNT_FINE])   ||
                    (r_cur[SEL_COUNT_MEDIUM] != r_last[SEL_COUNT_MEDIUM]) ||
                    (r_cur[SEL_COUNT_COARSE] != r_last[SEL_COUNT_COARSE]);
        case (i_display_mode)
            MODE_MASS:  changed = mass_diff;
            MODE_COUNT: changed = cnt_diff;
            default:    changed = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop && i_q_word.kind == QK_FIELD) begin
            r_cur[i_q_word.sel] <= i_q_word.data;
        end
        if (pop_end) begin
            for (int k = 0; k < 3; k++) begin
                r_mass[k] <= r_cur[k];
                r_cnt[k]  <= cnt[k];
            end
            r_changed <= changed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            for (int k = 0; k < NUM_FIELDS; k++) begin
                r_last[k] <= '0;
            end
        end else begin
            if (pop_end) begin
                r_out_valid <= 1'b1;
                r_last      <= r_cur;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid          = r_out_valid;
    assign o_mass_small     = r_mass[0];
    assign o_mass_mid       = r_mass[1];
    assign o_mass_large     = r_mass[2];
    assign o_count_fine     = r_cnt[0];
    assign o_count_medium   = r_cnt[1];
    assign o_count_coarse   = r_cnt[2];
    assign o_values_changed = r_changed;

endmodule

`default_nettype wire
